// File: src/cubic_anisotropy_field_cell_defines.svh
// Assertion macros shared by the checker of the cubic anisotropy field cell.
// Each macro expects signals named aclk and aresetn in the scope where it is used.
`ifndef CUBIC_ANISOTROPY_FIELD_CELL_DEFINES_SVH
`define CUBIC_ANISOTROPY_FIELD_CELL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// What must hold in the cycle after a reset edge.
`define CAF_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error(msg);

`endif

// File: src/caf_pkg.sv
// Types and constants of the cubic anisotropy field cell.
// Used by every module of the block; depends on nothing else.
package caf_pkg;

    localparam int MAG_W     = 24;
    localparam int AX_W      = 20;
    localparam int D_W       = 24;
    localparam int FIELD_W   = 32;
    localparam int EN_W      = 40;
    localparam int CFG_W     = 60;
    localparam int CFG_IDX_W = 3;

    // Largest magnitude of a direction cosine, Q2.22.
    localparam logic [D_W-2:0] D_MAG_MAX = {(D_W-1){1'b1}};

    localparam logic [CFG_W-1:0] AXIS_ONE_RST   = {40'd0, 20'h40000};
    localparam logic [CFG_W-1:0] AXIS_TWO_RST   = {20'd0, 20'h40000, 20'd0};
    localparam logic [CFG_W-1:0] AXIS_THREE_RST = {20'h40000, 40'd0};

    typedef struct packed {
        logic signed [MAG_W-1:0] mag_x;
        logic signed [MAG_W-1:0] mag_y;
        logic signed [MAG_W-1:0] mag_z;
        logic                    occupied;
    } caf_in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] field_x;
        logic signed [FIELD_W-1:0] field_y;
        logic signed [FIELD_W-1:0] field_z;
        logic signed [EN_W-1:0]    energy_density;
    } caf_out_t;

    // Travels with the data down the pipeline.
    typedef struct packed {
        logic valid;
        logic occupied;
    } caf_ctl_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AXIS_ONE   = 3'd0,
        CFG_AXIS_TWO   = 3'd1,
        CFG_AXIS_THREE = 3'd2,
        CFG_INV_SAT    = 3'd3,
        CFG_K1_DENSITY = 3'd4,
        CFG_K2_DENSITY = 3'd5,
        CFG_K1_FIELD   = 3'd6,
        CFG_K2_FIELD   = 3'd7
    } caf_cfg_idx_t;

endpackage

// File: src/caf_dcos.sv
// Direction cosine pipeline: projects the magnetization on the three easy axes
// and scales by 1/Ms, four register stages. Depends on caf_pkg.
module caf_dcos
    import caf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  caf_ctl_t                in_ctl,
    input  logic signed [MAG_W-1:0] mag [3],
    input  logic [CFG_W-1:0]        axis [3],
    input  logic [31:0]             inv_sat,
    output caf_ctl_t                d_ctl,
    output logic signed [D_W-1:0]   d [3]
);

    logic signed [AX_W-1:0] e [3][3];

    logic signed [43:0] prod_next [3][3];
    logic signed [43:0] prod_reg  [3][3];
    logic signed [45:0] dot       [3];
    logic signed [45:0] dabs      [3];
    logic [44:0]        mag_next  [3];
    logic [44:0]        mag_reg   [3];
    logic               neg2_next [3];
    logic               neg2_reg  [3];
    logic [63:0]        plo_next  [3];
    logic [63:0]        plo_reg   [3];
    logic [44:0]        phi_next  [3];
    logic [44:0]        phi_reg   [3];
    logic               neg3_reg  [3];
    logic [45:0]        qsum      [3];
    logic [41:0]        qv        [3];
    logic [D_W-2:0]     dmag      [3];
    logic signed [D_W-1:0] dpos   [3];
    logic signed [D_W-1:0] d_next [3];
    logic signed [D_W-1:0] d_reg  [3];

    caf_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e[i][0] = axis[i][19:0];
            e[i][1] = axis[i][39:20];
            e[i][2] = axis[i][59:40];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[i][c] = mag[c] * e[i][c];
            end
        end
    end

    // The scaling multiply works on the magnitude so that it truncates toward zero.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dot[i]       = prod_reg[i][0] + prod_reg[i][1] + prod_reg[i][2];
            dabs[i]      = dot[i][45] ? -dot[i] : dot[i];
            mag_next[i]  = dabs[i][44:0];
            neg2_next[i] = dot[i][45];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            plo_next[i] = mag_reg[i][31:0] * inv_sat;
            phi_next[i] = mag_reg[i][44:32] * inv_sat;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qsum[i]   = {1'b0, phi_reg[i]} + {14'd0, plo_reg[i][63:32]};
            qv[i]     = qsum[i][45:4];
            dmag[i]   = (qv[i] > {19'd0, D_MAG_MAX}) ? D_MAG_MAX : qv[i][D_W-2:0];
            dpos[i]   = {1'b0, dmag[i]};
            d_next[i] = neg3_reg[i] ? -dpos[i] : dpos[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end else if (en) begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            mag_reg  <= mag_next;
            neg2_reg <= neg2_next;
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            neg3_reg <= neg2_reg;
            d_reg    <= d_next;
        end
    end

    assign d_ctl = ctl4_reg;
    assign d     = d_reg;

endmodule

// File: src/caf_terms.sv
// Polynomial terms of the cubic energy: squares, cross products, the K1 and K2
// field terms per axis and the two energy sums, three register stages. Depends on caf_pkg.
module caf_terms
    import caf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  caf_ctl_t              d_ctl,
    input  logic signed [D_W-1:0] d [3],
    output caf_ctl_t              t_ctl,
    output logic signed [26:0]    a [3],
    output logic signed [28:0]    b [3],
    output logic signed [29:0]    e1,
    output logic signed [29:0]    e2
);

    // Index k of a cross term names the axis that is left out of the pair.
    logic signed [47:0] sqp       [3];
    logic signed [47:0] crossp    [3];
    logic signed [24:0] sq_next   [3];
    logic signed [24:0] sq_reg    [3];
    logic signed [24:0] q_next    [3];
    logic signed [24:0] q5_reg    [3];
    logic signed [D_W-1:0] d5_reg [3];

    logic signed [25:0] ssum      [3];
    logic signed [49:0] ap        [3];
    logic signed [26:0] a_next    [3];
    logic signed [26:0] a6_reg    [3];
    logic signed [48:0] pp;
    logic signed [25:0] p_next;
    logic signed [25:0] p6_reg;
    logic signed [49:0] eep       [3];
    logic signed [26:0] ee_next   [3];
    logic signed [26:0] ee6_reg   [3];
    logic signed [24:0] q6_reg    [3];

    logic signed [50:0] bp        [3];
    logic signed [28:0] b_next    [3];
    logic signed [28:0] b7_reg    [3];
    logic signed [51:0] e2p;
    logic signed [29:0] e1_next;
    logic signed [29:0] e2_next;
    logic signed [29:0] e1_reg;
    logic signed [29:0] e2_reg;
    logic signed [26:0] a7_reg    [3];

    caf_ctl_t ctl5_reg, ctl6_reg, ctl7_reg;

    always_comb begin
        crossp[0] = d[1] * d[2];
        crossp[1] = d[0] * d[2];
        crossp[2] = d[0] * d[1];
        for (int i = 0; i < 3; i++) begin
            sqp[i]     = d[i] * d[i];
            sq_next[i] = sqp[i][46:22];
            q_next[i]  = crossp[i][46:22];
        end
    end

    always_comb begin
        ssum[0] = sq_reg[1] + sq_reg[2];
        ssum[1] = sq_reg[0] + sq_reg[2];
        ssum[2] = sq_reg[0] + sq_reg[1];
        eep[0]  = sq_reg[1] * sq_reg[2];
        eep[1]  = sq_reg[0] * sq_reg[2];
        eep[2]  = sq_reg[0] * sq_reg[1];
        for (int i = 0; i < 3; i++) begin
            ap[i]      = d5_reg[i] * ssum[i];
            a_next[i]  = ap[i][48:22];
            ee_next[i] = eep[i][48:22];
        end
        pp     = q5_reg[2] * d5_reg[2];
        p_next = pp[47:22];
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bp[i]     = p6_reg * q6_reg[i];
            b_next[i] = bp[i][50:22];
        end
        e2p     = p6_reg * p6_reg;
        e2_next = e2p[51:22];
        e1_next = ee6_reg[0] + ee6_reg[1] + ee6_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl5_reg <= '0;
            ctl6_reg <= '0;
            ctl7_reg <= '0;
        end else if (en) begin
            ctl5_reg <= d_ctl;
            ctl6_reg <= ctl5_reg;
            ctl7_reg <= ctl6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg  <= sq_next;
            q5_reg  <= q_next;
            d5_reg  <= d;
            a6_reg  <= a_next;
            p6_reg  <= p_next;
            ee6_reg <= ee_next;
            q6_reg  <= q5_reg;
            b7_reg  <= b_next;
            e1_reg  <= e1_next;
            e2_reg  <= e2_next;
            a7_reg  <= a6_reg;
        end
    end

    assign t_ctl = ctl7_reg;
    assign a     = a7_reg;
    assign b     = b7_reg;
    assign e1    = e1_reg;
    assign e2    = e2_reg;

endmodule

// File: src/caf_comb.sv
// Field and energy assembly: maps the per-axis terms back to x, y, z, applies
// the constants and saturates, three register stages. Depends on caf_pkg.
module caf_comb
    import caf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  caf_ctl_t           t_ctl,
    input  logic signed [26:0] a [3],
    input  logic signed [28:0] b [3],
    input  logic signed [29:0] e1,
    input  logic signed [29:0] e2,
    input  logic [CFG_W-1:0]   axis [3],
    input  logic signed [31:0] k1_density,
    input  logic signed [31:0] k2_density,
    input  logic signed [31:0] k1_field_coef,
    input  logic signed [31:0] k2_field_coef,
    output caf_ctl_t           res_ctl,
    output caf_out_t           res
);

    logic signed [AX_W-1:0] e [3][3];

    logic signed [46:0] ea_next [3][3];
    logic signed [46:0] ea_reg  [3][3];
    logic signed [48:0] eb_next [3][3];
    logic signed [48:0] eb_reg  [3][3];
    logic signed [61:0] ek1_next, ek2_next;
    logic signed [61:0] ek1_reg, ek2_reg;

    logic signed [47:0] asum    [3];
    logic signed [48:0] bsum    [3];
    logic signed [29:0] ac_next [3];
    logic signed [29:0] ac_reg  [3];
    logic signed [30:0] bc_next [3];
    logic signed [30:0] bc_reg  [3];
    logic signed [62:0] esum;
    logic signed [40:0] esh;
    logic signed [EN_W-1:0] en_next;
    logic signed [EN_W-1:0] en9_reg;

    logic signed [61:0] fa_next [3];
    logic signed [61:0] fa_reg  [3];
    logic signed [62:0] fb_next [3];
    logic signed [62:0] fb_reg  [3];
    logic signed [EN_W-1:0] en10_reg;

    logic signed [63:0] fsum    [3];
    logic signed [41:0] fsh     [3];
    logic signed [FIELD_W-1:0] fsat [3];

    caf_ctl_t ctl8_reg, ctl9_reg, ctl10_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e[i][0] = axis[i][19:0];
            e[i][1] = axis[i][39:20];
            e[i][2] = axis[i][59:40];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
                ea_next[i][c] = e[i][c] * a[i];
                eb_next[i][c] = e[i][c] * b[i];
            end
        end
        ek1_next = k1_density * e1;
        ek2_next = k2_density * e2;
    end

    // Energy saturates to 40 bits where the two top bits of the shifted sum disagree.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            asum[c]    = ea_reg[0][c] + ea_reg[1][c] + ea_reg[2][c];
            bsum[c]    = eb_reg[0][c] + eb_reg[1][c] + eb_reg[2][c];
            ac_next[c] = asum[c][47:18];
            bc_next[c] = bsum[c][48:18];
        end
        esum = ek1_reg + ek2_reg;
        esh  = esum[62:22];
        if (esh[40] == esh[39]) begin
            en_next = esh[EN_W-1:0];
        end else if (esh[40]) begin
            en_next = {1'b1, {(EN_W-1){1'b0}}};
        end else begin
            en_next = {1'b0, {(EN_W-1){1'b1}}};
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            fa_next[c] = k1_field_coef * ac_reg[c];
            fb_next[c] = k2_field_coef * bc_reg[c];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            fsum[c] = fa_reg[c] + fb_reg[c];
            fsh[c]  = fsum[c][63:22];
            if ((fsh[c][41:31] == '0) || (fsh[c][41:31] == '1)) begin
                fsat[c] = fsh[c][FIELD_W-1:0];
            end else if (fsh[c][41]) begin
                fsat[c] = {1'b1, {(FIELD_W-1){1'b0}}};
            end else begin
                fsat[c] = {1'b0, {(FIELD_W-1){1'b1}}};
            end
        end
        if (ctl10_reg.occupied) begin
            res.field_x        = fsat[0];
            res.field_y        = fsat[1];
            res.field_z        = fsat[2];
            res.energy_density = en10_reg;
        end else begin
            res = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl8_reg  <= '0;
            ctl9_reg  <= '0;
            ctl10_reg <= '0;
        end else if (en) begin
            ctl8_reg  <= t_ctl;
            ctl9_reg  <= ctl8_reg;
            ctl10_reg <= ctl9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ea_reg   <= ea_next;
            eb_reg   <= eb_next;
            ek1_reg  <= ek1_next;
            ek2_reg  <= ek2_next;
            ac_reg   <= ac_next;
            bc_reg   <= bc_next;
            en9_reg  <= en_next;
            fa_reg   <= fa_next;
            fb_reg   <= fb_next;
            en10_reg <= en9_reg;
        end
    end

    assign res_ctl = ctl10_reg;

endmodule

// File: src/cubic_anisotropy_field_cell.sv
// Cubic magnetocrystalline anisotropy field and energy density, one mesh cell per beat.
// Holds the configuration registers, the pipeline and the output skid stage.
// Depends on caf_pkg, caf_dcos, caf_terms and caf_comb.
//
// Input beats (s_valid/s_ready/s_data) carry one cell's magnetization and its
// occupied flag; result beats (m_valid/m_ready/m_data) carry the field vector and
// the energy density. An empty cell gives an all-zero result.
// The pipeline has ten register stages plus an output register, and one cell is
// taken every cycle while the receiver keeps up. The multipliers of each stage
// set this depth; no stage feeds back, so the rate is one beat per cycle unless
// the output stalls.
// When the receiver stalls, the first pending result moves into a skid register
// and the whole pipeline holds from the next cycle; s_ready comes straight from a
// flip-flop. Nothing is dropped or repeated.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at once and are
// to be made while no beat is in flight. Reset empties the pipeline and sets the
// axes to x, y and z with all constants zero.
module cubic_anisotropy_field_cell
    import caf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  caf_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output caf_out_t             m_data
);

    logic [CFG_W-1:0]   axis_one_reg, axis_two_reg, axis_three_reg;
    logic [31:0]        inv_sat_reg;
    logic signed [31:0] k1_density_reg, k2_density_reg;
    logic signed [31:0] k1_field_reg, k2_field_reg;

    logic [CFG_W-1:0]        axis [3];
    logic signed [MAG_W-1:0] mag  [3];
    caf_ctl_t                in_ctl, d_ctl, t_ctl, res_ctl;
    logic signed [D_W-1:0]   d    [3];
    logic signed [26:0]      a    [3];
    logic signed [28:0]      b    [3];
    logic signed [29:0]      e1, e2;
    caf_out_t                res;

    logic     en;
    logic     push;
    logic     out_valid_reg, out_valid_next;
    caf_out_t out_data_reg, out_data_next;
    logic     skid_valid_reg, skid_valid_next;
    caf_out_t skid_data_reg, skid_data_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_one_reg   <= AXIS_ONE_RST;
            axis_two_reg   <= AXIS_TWO_RST;
            axis_three_reg <= AXIS_THREE_RST;
            inv_sat_reg    <= '0;
            k1_density_reg <= '0;
            k2_density_reg <= '0;
            k1_field_reg   <= '0;
            k2_field_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (caf_cfg_idx_t'(cfg_index))
                CFG_AXIS_ONE:   axis_one_reg   <= cfg_wdata;
                CFG_AXIS_TWO:   axis_two_reg   <= cfg_wdata;
                CFG_AXIS_THREE: axis_three_reg <= cfg_wdata;
                CFG_INV_SAT:    inv_sat_reg    <= cfg_wdata[31:0];
                CFG_K1_DENSITY: k1_density_reg <= cfg_wdata[31:0];
                CFG_K2_DENSITY: k2_density_reg <= cfg_wdata[31:0];
                CFG_K1_FIELD:   k1_field_reg   <= cfg_wdata[31:0];
                CFG_K2_FIELD:   k2_field_reg   <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    assign axis[0] = axis_one_reg;
    assign axis[1] = axis_two_reg;
    assign axis[2] = axis_three_reg;

    assign mag[0] = s_data.mag_x;
    assign mag[1] = s_data.mag_y;
    assign mag[2] = s_data.mag_z;

    // The pipeline moves whenever the skid register is free.
    assign en      = !skid_valid_reg;
    assign s_ready = en;
    assign in_ctl  = '{valid: s_valid, occupied: s_data.occupied};

    caf_dcos u_dcos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (in_ctl),
        .mag     (mag),
        .axis    (axis),
        .inv_sat (inv_sat_reg),
        .d_ctl   (d_ctl),
        .d       (d)
    );

    caf_terms u_terms (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d_ctl   (d_ctl),
        .d       (d),
        .t_ctl   (t_ctl),
        .a       (a),
        .b       (b),
        .e1      (e1),
        .e2      (e2)
    );

    caf_comb u_comb (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .t_ctl         (t_ctl),
        .a             (a),
        .b             (b),
        .e1            (e1),
        .e2            (e2),
        .axis          (axis),
        .k1_density    (k1_density_reg),
        .k2_density    (k2_density_reg),
        .k1_field_coef (k1_field_reg),
        .k2_field_coef (k2_field_reg),
        .res_ctl       (res_ctl),
        .res           (res)
    );

    assign push = en && res_ctl.valid;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = res;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// File: src/caf_checker.sv
// Port-level checker of the cubic anisotropy field cell, bound to the top level.
// Depends on caf_pkg and the assertion macros in cubic_anisotropy_field_cell_defines.svh.
`include "cubic_anisotropy_field_cell_defines.svh"

module caf_checker
    import caf_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input caf_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input caf_out_t m_data
);

    // After reset nothing is pending and the input side is open.
    `CAF_ASSERT_RESET(a_reset_empty, !m_valid && s_ready, "results pending after reset")

    // An offered input beat stays offered and unchanged until it is taken.
    `CAF_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_data),
        "input beat withdrawn or changed before it was taken")

    // A result the receiver has not taken stays put.
    `CAF_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data),
        "stalled result changed or vanished")

    // The input side only closes after the output side has refused a beat.
    `CAF_ASSERT_NOW(a_ready_cause, !s_ready, m_valid && $past(m_valid && !m_ready),
        "input closed without an output stall")

    // Once a result is taken the skid register drains and the input reopens.
    `CAF_ASSERT_NEXT(a_ready_back, m_valid && m_ready, s_ready,
        "input still closed after a result was taken")

endmodule

bind cubic_anisotropy_field_cell caf_checker u_caf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
